/* rtl/core/assert_macros.svh */
// assertion macros shared by the rtl
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define EZT_ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
`define EZT_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`else
`define EZT_ASSERT_SAME(label, clk, rst_n, cond, prop)
`define EZT_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

/* rtl/core/ezt_pkg.sv */
// shared types, constants and rounding helpers for the pose to transform block
// no dependencies
`default_nettype none
package ezt_pkg;

    localparam int CORDIC_STEPS  = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int NUM_STEPS     = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
    localparam int STEP_W        = 5;
    localparam int CW            = 34;
    localparam int ANGLE_W       = 16;
    localparam int SHIFT_W       = 32;
    localparam int ENTRY_W       = 16;
    localparam int TRIG_W        = 22;
    localparam int PREP_STAGES   = 4;
    localparam int MAT_STAGES    = 5;
    localparam int LATENCY       = PREP_STAGES + NUM_STEPS + MAT_STAGES;

    localparam int TURN_UNITS    = 46080;
    localparam int HALF_UNITS    = 23040;
    localparam int QUARTER_UNITS = 11520;
    localparam logic [CW-1:0] CORDIC_GAIN = CW'(652032874);
    localparam logic [10:0] RECIP45_Q16 = 11'd1456;
    localparam logic [26:0] RECIP45_Q32 = 27'd95443718;
    localparam logic [5:0] DIV_CONST = 6'd45;
    localparam logic [CW-1:0] ONE_Q20 = CW'(1048576);

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 neg;
    } t_rot;

    function automatic logic signed [CW-1:0] atan_bin(input logic [STEP_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return $signed(CW'(v));
    endfunction

    // q2.30 to q1.20, nearest with ties away from zero, clamped to +-1, optional negate
    function automatic logic signed [TRIG_W-1:0] round_q20(input logic signed [CW-1:0] v,
                                                           input logic neg);
        logic [CW-1:0]            mag;
        logic [CW-1:0]            r;
        logic signed [TRIG_W-1:0] res;
        logic                     s;
        mag = v[CW-1] ? CW'(-v) : CW'(v);
        r   = (mag + CW'(512)) >> 10;
        if (r > ONE_Q20) begin
            r = ONE_Q20;
        end
        s   = v[CW-1] ^ neg;
        res = $signed(TRIG_W'(r));
        return s ? -res : res;
    endfunction

    // q60 to q1.14, nearest with ties away from zero, saturated to +-1
    function automatic logic signed [ENTRY_W-1:0] round_q14(input logic signed [63:0] v);
        logic [63:0]               mag;
        logic [63:0]               r;
        logic signed [ENTRY_W-1:0] res;
        mag = v[63] ? 64'(-v) : 64'(v);
        r   = (mag + 64'h0000_2000_0000_0000) >> 46;
        if (r > 64'd16384) begin
            r = 64'd16384;
        end
        res = $signed(ENTRY_W'(r));
        return v[63] ? -res : res;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/ezt_angle_prep.sv */
// angle reduction to a quarter turn and conversion to a binary angle
// depends on ezt_pkg
`default_nettype none
module ezt_angle_prep (
    input  wire logic                               i_clk,
    input  wire logic                               i_en,
    input  wire logic signed [ezt_pkg::ANGLE_W-1:0] i_angle,
    output ezt_pkg::t_rot                           o_rot
);
    import ezt_pkg::*;

    logic signed [17:0] w, m, fm;
    logic               fneg;
    logic [13:0]        mag;
    logic [24:0]        qp;

    logic [13:0] r_a_mag;
    logic        r_a_sgn, r_a_neg;
    logic [24:0] r_a_qp;

    logic [8:0]  q0;
    logic [14:0] r0;
    logic [8:0]  n_q;
    logic [5:0]  n_r;
    logic [8:0]  r_b_q;
    logic [5:0]  r_b_r;
    logic        r_b_sgn, r_b_neg;

    logic [27:0] n2;
    logic [54:0] prod;
    logic [8:0]  r_c_q;
    logic [22:0] r_c_t;
    logic        r_c_sgn, r_c_neg;

    logic [30:0]   zm;
    logic [CW-1:0] zw;
    t_rot          r_rot;

    always_comb begin
        w = 18'(i_angle);
        if (w >= 18'sd23040) begin
            m = w - 18'(TURN_UNITS);
        end else if (w < -18'sd23040) begin
            m = w + 18'(TURN_UNITS);
        end else begin
            m = w;
        end
        // half-turn fold keeps the angle within a quarter turn
        if (m > 18'(QUARTER_UNITS)) begin
            fm   = m - 18'(HALF_UNITS);
            fneg = 1'b1;
        end else if (m < -18'(QUARTER_UNITS)) begin
            fm   = m + 18'(HALF_UNITS);
            fneg = 1'b1;
        end else begin
            fm   = m;
            fneg = 1'b0;
        end
        mag = fm[17] ? 14'(-fm) : 14'(fm);
        qp  = 25'(mag) * 25'(RECIP45_Q16);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_mag <= mag;
            r_a_sgn <= fm[17];
            r_a_neg <= fneg;
            r_a_qp  <= qp;
        end
    end

    // quotient estimate is low by at most one
    always_comb begin
        q0 = r_a_qp[24:16];
        r0 = 15'(r_a_mag) - 15'(q0) * 15'(DIV_CONST);
        if (r0 >= 15'(DIV_CONST)) begin
            n_q = q0 + 9'd1;
            n_r = 6'(r0 - 15'(DIV_CONST));
        end else begin
            n_q = q0;
            n_r = 6'(r0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_q   <= n_q;
            r_b_r   <= n_r;
            r_b_sgn <= r_a_sgn;
            r_b_neg <= r_a_neg;
        end
    end

    // remainder part: floor((r * 2^22 + 22) / 45) through an exact reciprocal
    always_comb begin
        n2   = {r_b_r, 22'd22};
        prod = 55'(n2) * 55'(RECIP45_Q32);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_q   <= r_b_q;
            r_c_t   <= prod[54:32];
            r_c_sgn <= r_b_sgn;
            r_c_neg <= r_b_neg;
        end
    end

    always_comb begin
        zm = {r_c_q, 22'd0} + 31'(r_c_t);
        zw = r_c_sgn ? -CW'(zm) : CW'(zm);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot.x   <= $signed(CORDIC_GAIN);
            r_rot.y   <= '0;
            r_rot.z   <= $signed(zw);
            r_rot.neg <= r_c_neg;
        end
    end

    assign o_rot = r_rot;

endmodule
`default_nettype wire

/* rtl/core/ezt_cordic_cell.sv */
// one cordic rotation step, registered
// depends on ezt_pkg
`default_nettype none
module ezt_cordic_cell (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire logic [ezt_pkg::STEP_W-1:0]        i_step,
    input  ezt_pkg::t_rot                          i_rot,
    output ezt_pkg::t_rot                          o_rot
);
    import ezt_pkg::*;

    logic signed [CW-1:0] x, y, z, dx, dy, ang;
    t_rot                 n_rot, r_rot;

    always_comb begin
        x   = i_rot.x;
        y   = i_rot.y;
        z   = i_rot.z;
        dx  = y >>> i_step;
        dy  = x >>> i_step;
        ang = atan_bin(i_step);
        n_rot.neg = i_rot.neg;
        if (!z[CW-1]) begin
            n_rot.x = x - dx;
            n_rot.y = y + dy;
            n_rot.z = z - ang;
        end else begin
            n_rot.x = x + dx;
            n_rot.y = y - dy;
            n_rot.z = z + ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot <= n_rot;
        end
    end

    assign o_rot = r_rot;

endmodule
`default_nettype wire

/* rtl/core/ezt_matrix.sv */
// sine/cosine rounding and rotation matrix products, five register stages
// depends on ezt_pkg
`default_nettype none
module ezt_matrix (
    input  wire logic                                i_clk,
    input  wire logic                                i_en,
    input  ezt_pkg::t_rot                            i_rot_x,
    input  ezt_pkg::t_rot                            i_rot_y,
    input  ezt_pkg::t_rot                            i_rot_z,
    output logic signed [ezt_pkg::ENTRY_W-1:0]       o_r00,
    output logic signed [ezt_pkg::ENTRY_W-1:0]       o_r01,
    output logic signed [ezt_pkg::ENTRY_W-1:0]       o_r02,
    output logic signed [ezt_pkg::ENTRY_W-1:0]       o_r10,
    output logic signed [ezt_pkg::ENTRY_W-1:0]       o_r11,
    output logic signed [ezt_pkg::ENTRY_W-1:0]       o_r12,
    output logic signed [ezt_pkg::ENTRY_W-1:0]       o_r20,
    output logic signed [ezt_pkg::ENTRY_W-1:0]       o_r21,
    output logic signed [ezt_pkg::ENTRY_W-1:0]       o_r22
);
    import ezt_pkg::*;

    localparam int PW = 2 * TRIG_W;

    // stage 1: q1.20 sines and cosines
    logic signed [TRIG_W-1:0] r_sx, r_cx, r_sy, r_cy, r_sz, r_cz;
    // stage 2: pair products
    logic signed [PW-1:0] r_czcy, r_szcy, r_cysx, r_cycx, r_czsy, r_szsy;
    logic signed [PW-1:0] r_szcx, r_szsx, r_czcx, r_czsx;
    logic signed [TRIG_W-1:0] r2_sx, r2_cx, r2_sy;
    // stage 3: triple products split in high and low halves
    logic signed [PW:0]   n_ph [4];
    logic signed [PW-1:0] n_pl [4];
    logic signed [PW:0]   r_ph [4];
    logic signed [PW-1:0] r_pl [4];
    logic signed [PW-1:0] r3_czcy, r3_szcy, r3_cysx, r3_cycx;
    logic signed [PW-1:0] r3_szcx, r3_szsx, r3_czcx, r3_czsx;
    logic signed [TRIG_W-1:0] r3_sy;
    // stage 4: q60 entries
    logic signed [63:0] tri_p [4];
    logic signed [63:0] n_v [9];
    logic signed [63:0] r_v [9];
    // stage 5: q1.14 entries
    logic signed [ENTRY_W-1:0] r_e [9];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sx <= round_q20(i_rot_x.y, i_rot_x.neg);
            r_cx <= round_q20(i_rot_x.x, i_rot_x.neg);
            r_sy <= round_q20(i_rot_y.y, i_rot_y.neg);
            r_cy <= round_q20(i_rot_y.x, i_rot_y.neg);
            r_sz <= round_q20(i_rot_z.y, i_rot_z.neg);
            r_cz <= round_q20(i_rot_z.x, i_rot_z.neg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_czcy <= r_cz * r_cy;
            r_szcy <= r_sz * r_cy;
            r_cysx <= r_cy * r_sx;
            r_cycx <= r_cy * r_cx;
            r_czsy <= r_cz * r_sy;
            r_szsy <= r_sz * r_sy;
            r_szcx <= r_sz * r_cx;
            r_szsx <= r_sz * r_sx;
            r_czcx <= r_cz * r_cx;
            r_czsx <= r_cz * r_sx;
            r2_sx  <= r_sx;
            r2_cx  <= r_cx;
            r2_sy  <= r_sy;
        end
    end

    // order: czsy*sx, czsy*cx, szsy*sx, szsy*cx
    always_comb begin
        n_ph[0] = $signed(r_czsy[PW-1:21]) * r2_sx;
        n_pl[0] = $signed({1'b0, r_czsy[20:0]}) * r2_sx;
        n_ph[1] = $signed(r_czsy[PW-1:21]) * r2_cx;
        n_pl[1] = $signed({1'b0, r_czsy[20:0]}) * r2_cx;
        n_ph[2] = $signed(r_szsy[PW-1:21]) * r2_sx;
        n_pl[2] = $signed({1'b0, r_szsy[20:0]}) * r2_sx;
        n_ph[3] = $signed(r_szsy[PW-1:21]) * r2_cx;
        n_pl[3] = $signed({1'b0, r_szsy[20:0]}) * r2_cx;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                r_ph[k] <= n_ph[k];
                r_pl[k] <= n_pl[k];
            end
            r3_czcy <= r_czcy;
            r3_szcy <= r_szcy;
            r3_cysx <= r_cysx;
            r3_cycx <= r_cycx;
            r3_szcx <= r_szcx;
            r3_szsx <= r_szsx;
            r3_czcx <= r_czcx;
            r3_czsx <= r_czsx;
            r3_sy   <= r2_sy;
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            tri_p[k] = (64'(r_ph[k]) <<< 21) + 64'(r_pl[k]);
        end
        n_v[0] = 64'(r3_czcy) <<< 20;
        n_v[1] = tri_p[0] - (64'(r3_szcx) <<< 20);
        n_v[2] = tri_p[1] + (64'(r3_szsx) <<< 20);
        n_v[3] = 64'(r3_szcy) <<< 20;
        n_v[4] = tri_p[2] + (64'(r3_czcx) <<< 20);
        n_v[5] = tri_p[3] - (64'(r3_czsx) <<< 20);
        n_v[6] = -(64'(r3_sy) <<< 40);
        n_v[7] = 64'(r3_cysx) <<< 20;
        n_v[8] = 64'(r3_cycx) <<< 20;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 9; k++) begin
                r_v[k] <= n_v[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 9; k++) begin
                r_e[k] <= round_q14(r_v[k]);
            end
        end
    end

    assign o_r00 = r_e[0];
    assign o_r01 = r_e[1];
    assign o_r02 = r_e[2];
    assign o_r10 = r_e[3];
    assign o_r11 = r_e[4];
    assign o_r12 = r_e[5];
    assign o_r20 = r_e[6];
    assign o_r21 = r_e[7];
    assign o_r22 = r_e[8];

endmodule
`default_nettype wire

/* rtl/core/euler_zyx_pose_to_transform.sv */
// top level: euler zyx pose to 3x4 homogeneous transform
// depends on ezt_pkg, ezt_angle_prep, ezt_cordic_cell, ezt_matrix, assert_macros.svh
//
// usage:
//   input channel i_valid / o_ready carries one pose: three 32-bit translations and
//   roll, pitch, yaw in 1/128 degree. output channel o_valid / i_ready carries the
//   nine q1.14 rotation entries and the translation column.
//   a pose passes through angle reduction, then one cordic cell per step (16 cordic
//   steps) for each of the three angles, then products and rounding.
//   throughput is one transaction per cycle while the receiver does not stall; the whole pipeline advances together.
//   when the receiver stalls with a result on the output, every stage holds and
//   o_ready drops; an empty output slot lets the pipeline keep moving.
//   reset clears all valid bits; the pipeline comes out of reset empty and ready.
`default_nettype none
`include "assert_macros.svh"
module euler_zyx_pose_to_transform (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic signed [ezt_pkg::SHIFT_W-1:0]  i_shift_x,
    input  wire logic signed [ezt_pkg::SHIFT_W-1:0]  i_shift_y,
    input  wire logic signed [ezt_pkg::SHIFT_W-1:0]  i_shift_z,
    input  wire logic signed [ezt_pkg::ANGLE_W-1:0]  i_roll_angle,
    input  wire logic signed [ezt_pkg::ANGLE_W-1:0]  i_pitch_angle,
    input  wire logic signed [ezt_pkg::ANGLE_W-1:0]  i_yaw_angle,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic signed [ezt_pkg::ENTRY_W-1:0]       o_r00,
    output logic signed [ezt_pkg::ENTRY_W-1:0]       o_r01,
    output logic signed [ezt_pkg::ENTRY_W-1:0]       o_r02,
    output logic signed [ezt_pkg::ENTRY_W-1:0]       o_r10,
    output logic signed [ezt_pkg::ENTRY_W-1:0]       o_r11,
    output logic signed [ezt_pkg::ENTRY_W-1:0]       o_r12,
    output logic signed [ezt_pkg::ENTRY_W-1:0]       o_r20,
    output logic signed [ezt_pkg::ENTRY_W-1:0]       o_r21,
    output logic signed [ezt_pkg::ENTRY_W-1:0]       o_r22,
    output logic signed [ezt_pkg::SHIFT_W-1:0]       o_t0,
    output logic signed [ezt_pkg::SHIFT_W-1:0]       o_t1,
    output logic signed [ezt_pkg::SHIFT_W-1:0]       o_t2
);
    import ezt_pkg::*;

    logic                n_en;
    logic [LATENCY-1:0]  r_vld;
    logic [SHIFT_W-1:0]  r_tx [LATENCY];
    logic [SHIFT_W-1:0]  r_ty [LATENCY];
    logic [SHIFT_W-1:0]  r_tz [LATENCY];
    t_rot                w_chain [3][NUM_STEPS+1];

    assign n_en    = !r_vld[LATENCY-1] || i_ready;
    assign o_ready = n_en;
    assign o_valid = r_vld[LATENCY-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (n_en) begin
            r_vld <= {r_vld[LATENCY-2:0], i_valid};
        end
    end

    // translations ride alongside the rotation pipeline
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_tx[0] <= i_shift_x;
            r_ty[0] <= i_shift_y;
            r_tz[0] <= i_shift_z;
            for (int k = 1; k < LATENCY; k++) begin
                r_tx[k] <= r_tx[k-1];
                r_ty[k] <= r_ty[k-1];
                r_tz[k] <= r_tz[k-1];
            end
        end
    end

    ezt_angle_prep u_prep_x (
        .i_clk   (i_clk),
        .i_en    (n_en),
        .i_angle (i_roll_angle),
        .o_rot   (w_chain[0][0])
    );

    ezt_angle_prep u_prep_y (
        .i_clk   (i_clk),
        .i_en    (n_en),
        .i_angle (i_pitch_angle),
        .o_rot   (w_chain[1][0])
    );

    ezt_angle_prep u_prep_z (
        .i_clk   (i_clk),
        .i_en    (n_en),
        .i_angle (i_yaw_angle),
        .o_rot   (w_chain[2][0])
    );

    for (genvar a = 0; a < 3; a++) begin : g_lane
        for (genvar s = 0; s < NUM_STEPS; s++) begin : g_cell
            ezt_cordic_cell u_cell (
                .i_clk  (i_clk),
                .i_en   (n_en),
                .i_step (STEP_W'(s)),
                .i_rot  (w_chain[a][s]),
                .o_rot  (w_chain[a][s+1])
            );
        end
    end

    ezt_matrix u_matrix (
        .i_clk   (i_clk),
        .i_en    (n_en),
        .i_rot_x (w_chain[0][NUM_STEPS]),
        .i_rot_y (w_chain[1][NUM_STEPS]),
        .i_rot_z (w_chain[2][NUM_STEPS]),
        .o_r00   (o_r00),
        .o_r01   (o_r01),
        .o_r02   (o_r02),
        .o_r10   (o_r10),
        .o_r11   (o_r11),
        .o_r12   (o_r12),
        .o_r20   (o_r20),
        .o_r21   (o_r21),
        .o_r22   (o_r22)
    );

    assign o_t0 = r_tx[LATENCY-1];
    assign o_t1 = r_ty[LATENCY-1];
    assign o_t2 = r_tz[LATENCY-1];

    // a held result must freeze the input side
    `EZT_ASSERT_SAME(a_stall_blocks_input, i_clk, i_rst_n, o_valid && !i_ready, !o_ready)
    // an accepted pose enters the first stage
    `EZT_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_valid && o_ready, r_vld[0])
    // a frozen pipeline keeps every valid bit
    `EZT_ASSERT_NEXT(a_freeze_holds, i_clk, i_rst_n, !o_ready, $stable(r_vld))

endmodule
`default_nettype wire

/* dv/tb.sv */
// testbench for euler_zyx_pose_to_transform: random and directed poses, with a
// cordic sin/cos predictor and a field-by-field check of every transform
// depends on ezt_pkg and the rtl under rtl/core
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import ezt_pkg::*;

    typedef struct packed {
        logic signed [SHIFT_W-1:0] sx, sy, sz;
        logic signed [ANGLE_W-1:0] roll, pitch, yaw;
    } t_pose;

    typedef struct {
        logic signed [ENTRY_W-1:0] r[9];
        logic signed [SHIFT_W-1:0] t[3];
    } t_xform;

    localparam longint ATAN[24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
        64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

    logic i_clk, i_rst_n, i_valid, i_ready, o_ready, o_valid;
    logic signed [SHIFT_W-1:0] i_shift_x, i_shift_y, i_shift_z;
    logic signed [ANGLE_W-1:0] i_roll_angle, i_pitch_angle, i_yaw_angle;
    logic signed [ENTRY_W-1:0] o_r00, o_r01, o_r02, o_r10, o_r11, o_r12, o_r20, o_r21, o_r22;
    logic signed [SHIFT_W-1:0] o_t0, o_t1, o_t2;

    t_pose  pose_q[$];
    t_xform xform_q[$];
    int     n_sent = 0;
    int     n_err = 0;
    int     hold_cnt = 0;
    bit     hold_done = 0;
    bit     stim_done = 0;

    euler_zyx_pose_to_transform dut (.*);

    // nearest, ties away from zero
    function automatic longint round_away(input longint v, input int s);
        longint half;
        half = longint'(1) << (s - 1);
        if (v >= 0) return (v + half) >>> s;
        return -(((-v) + half) >>> s);
    endfunction

    function automatic longint clip(input longint v, input longint lim);
        return v > lim ? lim : (v < -lim ? -lim : v);
    endfunction

    // sine and cosine in q1.20 of an angle in 1/128 degree
    function automatic void cordic_sincos(input logic signed [ANGLE_W-1:0] a,
                                          output longint s, output longint c);
        longint m, z, x, y, mag, dx, dy;
        bit     flip;
        flip = 0;
        m = longint'(a) % TURN_UNITS;
        if (m < 0) m += TURN_UNITS;
        if (m >= HALF_UNITS) m -= TURN_UNITS;
        if (m > QUARTER_UNITS) begin
            m -= HALF_UNITS;
            flip = 1;
        end else if (m < -QUARTER_UNITS) begin
            m += HALF_UNITS;
            flip = 1;
        end
        mag = m < 0 ? -m : m;
        z = (mag * (longint'(1) << 32) + TURN_UNITS / 2) / TURN_UNITS;
        if (m < 0) z = -z;
        x = 652032874;
        y = 0;
        for (int i = 0; i < NUM_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN[i];
            end else begin
                x += dx; y -= dy; z += ATAN[i];
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = clip(round_away(x, 10), 1 << 20);
        s = clip(round_away(y, 10), 1 << 20);
    endfunction

    function automatic logic signed [ENTRY_W-1:0] to_entry(input longint v);
        return ENTRY_W'(clip(round_away(v, 46), 16384));
    endfunction

    function automatic t_xform pose_transform(input t_pose p);
        t_xform e;
        longint sx, cx, sy, cy, sz, cz, up;
        up = 1 << 20;
        cordic_sincos(p.roll, sx, cx);
        cordic_sincos(p.pitch, sy, cy);
        cordic_sincos(p.yaw, sz, cz);
        e.r[0] = to_entry(cz * cy * up);
        e.r[1] = to_entry(cz * sy * sx - sz * cx * up);
        e.r[2] = to_entry(cz * sy * cx + sz * sx * up);
        e.r[3] = to_entry(sz * cy * up);
        e.r[4] = to_entry(sz * sy * sx + cz * cx * up);
        e.r[5] = to_entry(sz * sy * cx - cz * sx * up);
        e.r[6] = to_entry(-sy * up * up);
        e.r[7] = to_entry(cy * sx * up);
        e.r[8] = to_entry(cy * cx * up);
        e.t[0] = p.sx;
        e.t[1] = p.sy;
        e.t[2] = p.sz;
        return e;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        n_err++;
    endtask

    function automatic logic signed [ANGLE_W-1:0] rand_angle();
        case ($urandom_range(0, 3))
            0: return ANGLE_W'($urandom_range(0, 2 * QUARTER_UNITS + 8) - QUARTER_UNITS - 4);
            1: return ANGLE_W'(int'($urandom_range(0, 8)) - 4 +
                               (int'($urandom_range(0, 3)) - 2) * QUARTER_UNITS);
            default: return ANGLE_W'($urandom);
        endcase
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
    end

    initial begin
        #5_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // stimulus: directed corners first, then random poses
    initial begin
        logic signed [ANGLE_W-1:0] corner[12];
        t_pose p;
        corner = '{16'sd0, 16'sh8000, 16'sd32767, 16'sd11520, -16'sd11520, 16'sd11521,
                   -16'sd11521, 16'sd23040, -16'sd23040, 16'sd23039, 16'sd5760, -16'sd17280};
        for (int i = 0; i < 12; i++) begin
            p.sx = i[0] ? 32'sh7fffffff : 32'sh80000000;
            p.sy = i[1] ? 32'sh80000000 : 32'sh7fffffff;
            p.sz = i[2] ? 32'sd0 : -32'sd1;
            p.roll = corner[i];
            p.pitch = corner[(i + 4) % 12];
            p.yaw = corner[(i + 8) % 12];
            pose_q = {pose_q, p};
        end
        for (int i = 0; i < 1040; i++) begin
            p.sx = $urandom;
            p.sy = $urandom;
            p.sz = $urandom;
            p.roll = rand_angle();
            p.pitch = rand_angle();
            p.yaw = rand_angle();
            pose_q = {pose_q, p};
        end
        stim_done = 1;
    end

    // driver
    always @(posedge i_clk) begin
        int idle_pct;
        t_pose p;
        idle_pct = n_sent < 350 ? 36 : (n_sent < 700 ? 47 : 0);
        if (!i_rst_n) begin
            i_valid <= 0;
            {i_shift_x, i_shift_y, i_shift_z} <= '0;
            {i_roll_angle, i_pitch_angle, i_yaw_angle} <= '0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                p = '{i_shift_x, i_shift_y, i_shift_z, i_roll_angle, i_pitch_angle, i_yaw_angle};
                xform_q = {xform_q, pose_transform(p)};
                n_sent++;
            end
            if (pose_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                p = pose_q.pop_front();
                i_valid <= 1;
                {i_shift_x, i_shift_y, i_shift_z} <= {p.sx, p.sy, p.sz};
                {i_roll_angle, i_pitch_angle, i_yaw_angle} <= {p.roll, p.pitch, p.yaw};
            end else begin
                i_valid <= 0;
            end
        end
    end

    // receiver backpressure, with one long hold-off so the pipeline fills
    always @(posedge i_clk) begin
        int idle_pct;
        idle_pct = n_sent < 350 ? 47 : (n_sent < 700 ? 36 : 0);
        if (!i_rst_n) begin
            i_ready <= 0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_ready <= 0;
        end else if (!hold_done && n_sent >= 800) begin
            hold_done <= 1;
            hold_cnt <= 120;
            i_ready <= 0;
        end else begin
            i_ready <= $urandom_range(0, 99) >= idle_pct;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_xform e;
        logic signed [ENTRY_W-1:0] got_r[9];
        logic signed [SHIFT_W-1:0] got_t[3];
        if (i_rst_n && o_valid && i_ready) begin
            got_r = '{o_r00, o_r01, o_r02, o_r10, o_r11, o_r12, o_r20, o_r21, o_r22};
            got_t = '{o_t0, o_t1, o_t2};
            if (xform_q.size() == 0) begin
                report_mismatch("unexpected transaction", 0, 0);
            end else begin
                e = xform_q.pop_front();
                for (int k = 0; k < 9; k++)
                    if (got_r[k] !== e.r[k])
                        report_mismatch($sformatf("r%0d%0d", k / 3, k % 3), got_r[k], e.r[k]);
                for (int k = 0; k < 3; k++)
                    if (got_t[k] !== e.t[k])
                        report_mismatch($sformatf("t%0d", k), got_t[k], e.t[k]);
            end
        end
    end

    initial begin
        wait (stim_done);
        @(posedge i_clk);
        while (pose_q.size() > 0 || i_valid || xform_q.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (n_err == 0 && xform_q.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire

/* sim.f */
+incdir+rtl/core
rtl/core/ezt_pkg.sv
rtl/core/ezt_angle_prep.sv
rtl/core/ezt_cordic_cell.sv
rtl/core/ezt_matrix.sv
rtl/core/euler_zyx_pose_to_transform.sv
dv/tb.sv
